>>> rtl/ismet_pkg.sv
package ismet_pkg;

  // Lattice geometry
  localparam int LATTICE_SIDE    = 16;
  localparam int SITES           = LATTICE_SIDE * LATTICE_SIDE;
  localparam int COORD_W         = $clog2(LATTICE_SIDE);
  localparam int SITE_W          = $clog2(SITES);
  localparam bit SIDE_ODD        = (LATTICE_SIDE % 2) == 1;
  localparam int BLOCKS_PER_SIDE = (LATTICE_SIDE + 1) / 2;

  // Field widths
  localparam int IN_COORD_W = 4;
  localparam int FRAC_W     = 32;
  localparam int THR_W      = 33;
  localparam int ENERGY_W   = 11;
  localparam int MAGNET_W   = 10;
  localparam int BLOCK_W    = 8;

  // Configuration port
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_SEL_BIT = 3;

  typedef enum logic {
    REG_THR_DIF4 = 1'b0,
    REG_THR_DIF8 = 1'b1
  } cfg_reg_t;

  // Reset values
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(64'h1_0000_0000);
  localparam logic signed [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SITES);
  localparam logic signed [MAGNET_W-1:0] MAGNET_RESET = MAGNET_W'(SITES);
  localparam logic signed [BLOCK_W-1:0]  BLOCK_RESET  =
    BLOCK_W'(BLOCKS_PER_SIDE * BLOCKS_PER_SIDE);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SITE_W-1:0]  site_t;

  // Outcome of evaluating one trial flip.
  typedef struct packed {
    logic                       acc;
    logic signed [ENERGY_W-1:0] energy_delta;
    logic signed [MAGNET_W-1:0] magnet_delta;
    logic signed [BLOCK_W-1:0]  block_delta;
  } flip_eval_t;

  // Brings an input coordinate into the lattice; at most three subtractions
  // are ever needed because the input is four bits and the side is four or more.
  function automatic coord_t reduce_coord(input logic [IN_COORD_W-1:0] v);
    logic [IN_COORD_W-1:0] x;
    x = v;
    for (int i = 0; i < 3; i++) begin
      if (int'(x) >= LATTICE_SIDE) begin
        x = x - IN_COORD_W'(LATTICE_SIDE);
      end
    end
    return COORD_W'(x);
  endfunction

  function automatic coord_t inc_wrap(input coord_t c);
    return (c == COORD_W'(LATTICE_SIDE - 1)) ? '0 : c + COORD_W'(1);
  endfunction

  function automatic coord_t dec_wrap(input coord_t c);
    return (c == '0) ? COORD_W'(LATTICE_SIDE - 1) : c - COORD_W'(1);
  endfunction

  function automatic site_t site_idx(input coord_t r, input coord_t c);
    return SITE_W'(int'(r) * LATTICE_SIDE + int'(c));
  endfunction

endpackage

>>> rtl/ismet_flip_eval.sv
// Combinational evaluation of one trial flip against the current lattice.
module ismet_flip_eval (
  input  logic [ismet_pkg::SITES-1:0]  spins,
  input  ismet_pkg::coord_t            row,
  input  ismet_pkg::coord_t            col,
  input  logic [ismet_pkg::FRAC_W-1:0] frac,
  input  logic [ismet_pkg::THR_W-1:0]  thr_dif4,
  input  logic [ismet_pkg::THR_W-1:0]  thr_dif8,
  output ismet_pkg::flip_eval_t        eval
);

  // Majority of a 2x2 block, bit order {tl, tr, bl, br}; a tie takes the top-left.
  function automatic logic signed [1:0] block_major(input logic [3:0] b);
    logic [2:0] ones;
    ones = 3'($countones(b));
    if (ones >= 3'd3) begin
      return 2'sd1;
    end else if (ones <= 3'd1) begin
      return -2'sd1;
    end
    return b[3] ? 2'sd1 : -2'sd1;
  endfunction

  // Change of one block's majority when the given site flips.
  function automatic logic signed [ismet_pkg::BLOCK_W-1:0] block_change(
    input logic [ismet_pkg::SITES-1:0] sp,
    input ismet_pkg::coord_t           br,
    input ismet_pkg::coord_t           bc,
    input ismet_pkg::site_t            site
  );
    ismet_pkg::coord_t br1;
    ismet_pkg::coord_t bc1;
    ismet_pkg::site_t  ix [4];
    logic [3:0]        old_b;
    logic [3:0]        new_b;
    logic signed [1:0] m_old;
    logic signed [1:0] m_new;
    br1   = ismet_pkg::inc_wrap(br);
    bc1   = ismet_pkg::inc_wrap(bc);
    ix[0] = ismet_pkg::site_idx(br, bc);
    ix[1] = ismet_pkg::site_idx(br, bc1);
    ix[2] = ismet_pkg::site_idx(br1, bc);
    ix[3] = ismet_pkg::site_idx(br1, bc1);
    for (int k = 0; k < 4; k++) begin
      old_b[3-k] = sp[ix[k]];
      new_b[3-k] = sp[ix[k]] ^ (ix[k] == site);
    end
    m_old = block_major(old_b);
    m_new = block_major(new_b);
    return ismet_pkg::BLOCK_W'(m_new) - ismet_pkg::BLOCK_W'(m_old);
  endfunction

  ismet_pkg::site_t  site;
  logic              s;
  logic [3:0]        nb;
  logic [2:0]        same_cnt;
  logic              acc;
  ismet_pkg::coord_t org_r [2];
  ismet_pkg::coord_t org_c [2];
  logic              use_r [2];
  logic              use_c [2];
  logic signed [ismet_pkg::BLOCK_W-1:0]  blk_sum;
  logic signed [ismet_pkg::ENERGY_W-1:0] e_delta;

  assign site = ismet_pkg::site_idx(row, col);
  assign s    = spins[site];

  assign nb = {spins[ismet_pkg::site_idx(row, ismet_pkg::dec_wrap(col))],
               spins[ismet_pkg::site_idx(row, ismet_pkg::inc_wrap(col))],
               spins[ismet_pkg::site_idx(ismet_pkg::dec_wrap(row), col)],
               spins[ismet_pkg::site_idx(ismet_pkg::inc_wrap(row), col)]};

  // Energy change is 4 * (neighbours aligned with the spin) - 8.
  assign same_cnt = 3'($countones(~(nb ^ {4{s}})));

  always_comb begin
    acc     = 1'b1;
    e_delta = '0;
    case (same_cnt)
      3'd0:    e_delta = -ismet_pkg::ENERGY_W'(8);
      3'd1:    e_delta = -ismet_pkg::ENERGY_W'(4);
      3'd2:    e_delta = '0;
      3'd3: begin
        e_delta = ismet_pkg::ENERGY_W'(4);
        acc     = {1'b0, frac} <= thr_dif4;
      end
      default: begin
        e_delta = ismet_pkg::ENERGY_W'(8);
        acc     = {1'b0, frac} <= thr_dif8;
      end
    endcase
  end

  // A site belongs to its own block and, on an odd lattice, also to the
  // wrapped last block row or column when it lies in row or column zero.
  always_comb begin
    org_r[0] = row & ~ismet_pkg::COORD_W'(1);
    org_c[0] = col & ~ismet_pkg::COORD_W'(1);
    org_r[1] = ismet_pkg::COORD_W'(ismet_pkg::LATTICE_SIDE - 1);
    org_c[1] = ismet_pkg::COORD_W'(ismet_pkg::LATTICE_SIDE - 1);
    use_r[0] = 1'b1;
    use_c[0] = 1'b1;
    use_r[1] = ismet_pkg::SIDE_ODD && (row == '0);
    use_c[1] = ismet_pkg::SIDE_ODD && (col == '0);
    blk_sum  = '0;
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        if (use_r[a] && use_c[b]) begin
          blk_sum = blk_sum + block_change(spins, org_r[a], org_c[b], site);
        end
      end
    end
  end

  always_comb begin
    eval.acc          = acc;
    eval.energy_delta = acc ? e_delta : '0;
    eval.magnet_delta = !acc ? '0 :
                        (s ? -ismet_pkg::MAGNET_W'(2) : ismet_pkg::MAGNET_W'(2));
    eval.block_delta  = acc ? blk_sum : '0;
  end

endmodule

>>> rtl/ising_metropolis_step.sv
// Channel | Prefix | Handshake     | Fields
// --------+--------+---------------+-----------------------------------------------------------
// input   | in_    | valid / stall | site_col, site_row, random_fraction
// result  | out_   | valid / stall | accepted, total_energy, magnetization, block_magnetization
// config  | none   | psel, penable | pwrite, paddr, pwdata, prdata; pready tied high
//
// One transaction can be taken every cycle while the result side does not stall. A trial
// sits in the input register while its flip is evaluated against the lattice flip-flops;
// the lattice and the result register load together as it leaves, so the following trial
// always sees the updated lattice.
// Reset (rst_n low, synchronous) sets every spin to +1, the totals to their cold-start values
// and both thresholds to one. A stalled result stalls the input only while a trial waits.
module ising_metropolis_step (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ismet_pkg::IN_COORD_W-1:0]     in_site_col,
  input  logic [ismet_pkg::IN_COORD_W-1:0]     in_site_row,
  input  logic [ismet_pkg::FRAC_W-1:0]         in_random_fraction,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_accepted,
  output logic signed [ismet_pkg::ENERGY_W-1:0] out_total_energy,
  output logic signed [ismet_pkg::MAGNET_W-1:0] out_magnetization,
  output logic signed [ismet_pkg::BLOCK_W-1:0]  out_block_magnetization,

  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ismet_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ismet_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ismet_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                 pready
);

  // Configuration registers. The two thresholds sit eight bytes apart, so one
  // address bit selects between them.
  logic [ismet_pkg::THR_W-1:0] thr_dif4_r;
  logic [ismet_pkg::THR_W-1:0] thr_dif8_r;
  logic                        cfg_wr;
  ismet_pkg::cfg_reg_t         cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = ismet_pkg::cfg_reg_t'(paddr[ismet_pkg::CFG_SEL_BIT]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_dif4_r <= ismet_pkg::THR_RESET;
      thr_dif8_r <= ismet_pkg::THR_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        ismet_pkg::REG_THR_DIF4: thr_dif4_r <= pwdata[ismet_pkg::THR_W-1:0];
        ismet_pkg::REG_THR_DIF8: thr_dif8_r <= pwdata[ismet_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      ismet_pkg::REG_THR_DIF4:
        prdata = ismet_pkg::CFG_DATA_W'(thr_dif4_r);
      ismet_pkg::REG_THR_DIF8:
        prdata = ismet_pkg::CFG_DATA_W'(thr_dif8_r);
      default:
        prdata = '0;
    endcase
  end

  // Pipeline control: the result register moves whenever it is empty or being
  // taken, and the input register follows it.
  logic s1_valid_r;
  logic out_valid_r;
  logic advance;
  logic fire;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign fire     = s1_valid_r && advance;

  // Input register; the coordinates are reduced onto the lattice on the way in.
  ismet_pkg::coord_t           s1_row_r;
  ismet_pkg::coord_t           s1_col_r;
  logic [ismet_pkg::FRAC_W-1:0] s1_frac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_row_r  <= ismet_pkg::reduce_coord(in_site_row);
      s1_col_r  <= ismet_pkg::reduce_coord(in_site_col);
      s1_frac_r <= in_random_fraction;
    end
  end

  // Lattice and running totals. A set bit is spin +1.
  logic [ismet_pkg::SITES-1:0]           spin_r;
  logic [ismet_pkg::SITES-1:0]           spin_nxt;
  logic signed [ismet_pkg::ENERGY_W-1:0] energy_r;
  logic signed [ismet_pkg::ENERGY_W-1:0] energy_nxt;
  logic signed [ismet_pkg::MAGNET_W-1:0] magnet_r;
  logic signed [ismet_pkg::MAGNET_W-1:0] magnet_nxt;
  logic signed [ismet_pkg::BLOCK_W-1:0]  block_r;
  logic signed [ismet_pkg::BLOCK_W-1:0]  block_nxt;
  ismet_pkg::flip_eval_t                 eval;

  ismet_flip_eval u_flip_eval (
    .spins    (spin_r),
    .row      (s1_row_r),
    .col      (s1_col_r),
    .frac     (s1_frac_r),
    .thr_dif4 (thr_dif4_r),
    .thr_dif8 (thr_dif8_r),
    .eval     (eval)
  );

  // The deltas from the evaluator are already zero for a rejected flip, so the
  // totals only need the transaction to be leaving the input register.
  always_comb begin
    spin_nxt   = spin_r;
    energy_nxt = energy_r + eval.energy_delta;
    magnet_nxt = magnet_r + eval.magnet_delta;
    block_nxt  = block_r + eval.block_delta;
    if (eval.acc) begin
      spin_nxt[ismet_pkg::site_idx(s1_row_r, s1_col_r)] =
        ~spin_r[ismet_pkg::site_idx(s1_row_r, s1_col_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_r   <= '1;
      energy_r <= ismet_pkg::ENERGY_RESET;
      magnet_r <= ismet_pkg::MAGNET_RESET;
      block_r  <= ismet_pkg::BLOCK_RESET;
    end else if (fire) begin
      spin_r   <= spin_nxt;
      energy_r <= energy_nxt;
      magnet_r <= magnet_nxt;
      block_r  <= block_nxt;
    end
  end

  // Result register, loaded with the totals after this transaction.
  logic                                  out_accepted_r;
  logic signed [ismet_pkg::ENERGY_W-1:0] out_energy_r;
  logic signed [ismet_pkg::MAGNET_W-1:0] out_magnet_r;
  logic signed [ismet_pkg::BLOCK_W-1:0]  out_block_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_accepted_r <= eval.acc;
      out_energy_r   <= energy_nxt;
      out_magnet_r   <= magnet_nxt;
      out_block_r    <= block_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_accepted            = out_accepted_r;
  assign out_total_energy        = out_energy_r;
  assign out_magnetization       = out_magnet_r;
  assign out_block_magnetization = out_block_r;

  // A rejected flip must leave the lattice and every total untouched.
  a_reject_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !eval.acc) |=> (spin_r == $past(spin_r)) && (energy_r == $past(energy_r))
      && (magnet_r == $past(magnet_r)) && (block_r == $past(block_r)))
    else $error("rejected flip changed the lattice state");

  // An accepted flip changes the magnetization by exactly two.
  a_accept_moves_magnet: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && eval.acc) |=> (magnet_r - $past(magnet_r) == ismet_pkg::MAGNET_W'(2))
      || ($past(magnet_r) - magnet_r == ismet_pkg::MAGNET_W'(2)))
    else $error("accepted flip did not move magnetization by two");

  // A transaction leaving the input register always lands in the result register.
  a_fire_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("evaluated transaction lost before the result register");

  // The input side is only held back while a transaction waits in the input register.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a waiting transaction");

endmodule
